@@ hw/rtl/hsc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the heading steering controller.
package hsc_pkg;

  localparam int ATAN_ITERATIONS_DEF = 14;
  localparam int ATAN_ITERATIONS_MAX = 20;

  // CORDIC datapath widths: coordinates are differences scaled by 1024,
  // the angle accumulator is Q.20 radians.
  localparam int CW = 30;
  localparam int ZW = 25;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [ZW-1:0] angle_t;

  localparam angle_t HALF_PI_Q20 = 25'sd1647099;
  localparam angle_t Z_ROUND     = 25'sd128;

  localparam logic signed [16:0] PI_Q12     = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;

  localparam logic [14:0] PI_PLUS_ONE_Q12 = 15'd16964;
  // Magnitude limits below which the gain is applied again (0.2 and 0.05).
  localparam logic [14:0] BOOST1_LIMIT = 15'd820;
  localparam logic [15:0] BOOST2_LIMIT = 16'd205;

  typedef enum logic [1:0] {
    REG_TURN_THRESHOLD = 2'd0,
    REG_TURN_GAIN      = 2'd1,
    REG_CRUISE_SPEED   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [13:0] turn_threshold;
    logic [12:0] turn_gain;
    logic [10:0] cruise_speed;
  } cfg_t;

  // Fields that ride along with the CORDIC stages.
  typedef struct packed {
    logic [1:0]         id;
    logic signed [14:0] head;
    logic               zero;
  } side_t;

  // Fields that ride along with the gain stages.
  typedef struct packed {
    logic [1:0]  id;
    logic [10:0] speed;
    logic        neg;
  } cmd_side_t;

  // Arctangent of 2^-i in Q.20 radians.
  function automatic angle_t atan_q20(input int i);
    angle_t r;
    unique case (i)
      0:       r = 25'sd823550;
      1:       r = 25'sd486170;
      2:       r = 25'sd256879;
      3:       r = 25'sd130396;
      4:       r = 25'sd65451;
      5:       r = 25'sd32757;
      6:       r = 25'sd16383;
      7:       r = 25'sd8192;
      8:       r = 25'sd4096;
      9:       r = 25'sd2048;
      10:      r = 25'sd1024;
      11:      r = 25'sd512;
      12:      r = 25'sd256;
      13:      r = 25'sd128;
      14:      r = 25'sd64;
      15:      r = 25'sd32;
      16:      r = 25'sd16;
      17:      r = 25'sd8;
      18:      r = 25'sd4;
      19:      r = 25'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Magnitude times Q5.8 gain, rounded to nearest.
  function automatic logic [21:0] gain_mul(input logic [15:0] mag, input logic [12:0] gain);
    logic [29:0] prod;
    prod = 30'(mag) * 30'(gain) + 30'd128;
    return prod[29:8];
  endfunction

endpackage

@@ hw/rtl/hsc_cordic.sv @@
// Pipelined vectoring CORDIC that turns the robot-to-target offset into a Q.20 bearing.
module hsc_cordic
  import hsc_pkg::*;
#(
  parameter int ITER = ATAN_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         robot_id,
  input  logic [15:0]        robot_x,
  input  logic [15:0]        robot_y,
  input  logic signed [14:0] robot_heading,
  input  logic [15:0]        target_x,
  input  logic [15:0]        target_y,
  output logic               out_valid,
  input  logic               out_ready,
  output angle_t             out_z,
  output side_t              out_side
);

  coord_t x [0:ITER];
  coord_t y [0:ITER];
  angle_t z [0:ITER];
  side_t  side [0:ITER];
  logic   v [0:ITER];
  logic   rdy [0:ITER+1];

  logic signed [16:0] dx, dy;
  coord_t px, py, sx, sy;
  angle_t sz;

  // The pre-rotation folds the left half plane onto the right one.
  always_comb begin
    dx = $signed({1'b0, target_x}) - $signed({1'b0, robot_x});
    dy = $signed({1'b0, target_y}) - $signed({1'b0, robot_y});
    px = {{(CW-27){dx[16]}}, dx, 10'b0};
    py = {{(CW-27){dy[16]}}, dy, 10'b0};
    sx = px;
    sy = py;
    sz = '0;
    if (px < 0) begin
      if (py >= 0) begin
        sx = py;
        sy = -px;
        sz = HALF_PI_Q20;
      end else begin
        sx = -py;
        sy = px;
        sz = -HALF_PI_Q20;
      end
    end
  end

  assign rdy[ITER+1] = out_ready;
  assign rdy[0]      = !v[0] || rdy[1];
  assign in_ready    = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x[0]    <= sx;
      y[0]    <= sy;
      z[0]    <= sz;
      side[0] <= '{id: robot_id, head: robot_heading, zero: (dx == '0) && (dy == '0)};
    end
  end

  for (genvar k = 1; k <= ITER; k++) begin : g_iter
    localparam int I = k - 1;
    coord_t xs, ys, xn, yn;
    angle_t zn;

    always_comb begin
      xs = x[k-1] >>> I;
      ys = y[k-1] >>> I;
      if (y[k-1] > 0) begin
        xn = x[k-1] + ys;
        yn = y[k-1] - xs;
        zn = z[k-1] + atan_q20(I);
      end else begin
        xn = x[k-1] - ys;
        yn = y[k-1] + xs;
        zn = z[k-1] - atan_q20(I);
      end
    end

    assign rdy[k] = !v[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        x[k]    <= xn;
        y[k]    <= yn;
        z[k]    <= zn;
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = v[ITER];
  assign out_z     = z[ITER];
  assign out_side  = side[ITER];

endmodule

@@ hw/rtl/hsc_error.sv @@
// Bearing rounding and selection of the shorter heading error, plus the forward speed.
module hsc_error
  import hsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  angle_t      in_z,
  input  side_t       in_side,
  input  logic [13:0] turn_threshold,
  input  logic [10:0] cruise_speed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_mag,
  output cmd_side_t   out_side
);

  // Round stage.
  logic               v_r, rdy_r;
  logic signed [14:0] brg;
  logic signed [14:0] head_r;
  logic [1:0]         id_r;

  // Candidate stage.
  logic               v_c, rdy_c;
  logic signed [16:0] m1, m2;
  logic [15:0]        a1, a2;
  logic [1:0]         id_c;

  // Select stage.
  logic               v_s, rdy_s;

  angle_t             zsum;
  logic signed [16:0] zr;
  logic signed [14:0] brg_next;
  logic signed [16:0] m1_next, m2_next;
  logic [15:0]        a1_next, a2_next;
  logic               take_raw;
  logic [15:0]        mag_next;
  logic               neg_next;

  always_comb begin
    zsum = in_z + Z_ROUND;
    zr   = 17'(zsum >>> 8);
    if (in_side.zero) begin
      brg_next = '0;
    end else if (zr > PI_Q12) begin
      brg_next = 15'(PI_Q12);
    end else if (zr < -PI_Q12) begin
      brg_next = 15'(-PI_Q12);
    end else begin
      brg_next = zr[14:0];
    end
  end

  always_comb begin
    m1_next = 17'(brg) - 17'(head_r);
    m2_next = (m1_next > 0) ? m1_next - TWO_PI_Q12 : m1_next + TWO_PI_Q12;
    a1_next = m1_next[16] ? 16'(-m1_next) : m1_next[15:0];
    a2_next = m2_next[16] ? 16'(-m2_next) : m2_next[15:0];
  end

  // On a tie the wrapped candidate wins.
  always_comb begin
    take_raw = a1 < a2;
    mag_next = take_raw ? a1 : a2;
    neg_next = take_raw ? m1[16] : m2[16];
  end

  assign rdy_s    = !v_s || out_ready;
  assign rdy_c    = !v_c || rdy_s;
  assign rdy_r    = !v_r || rdy_c;
  assign in_ready = rdy_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= 1'b0;
      v_c <= 1'b0;
      v_s <= 1'b0;
    end else begin
      if (rdy_r) begin
        v_r <= in_valid;
      end
      if (rdy_c) begin
        v_c <= v_r;
      end
      if (rdy_s) begin
        v_s <= v_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_r) begin
      brg    <= brg_next;
      head_r <= in_side.head;
      id_r   <= in_side.id;
    end
    if (rdy_c) begin
      m1   <= m1_next;
      m2   <= m2_next;
      a1   <= a1_next;
      a2   <= a2_next;
      id_c <= id_r;
    end
    if (rdy_s) begin
      out_mag        <= mag_next;
      out_side.id    <= id_c;
      out_side.neg   <= neg_next;
      out_side.speed <= (mag_next < {2'b0, turn_threshold}) ? cruise_speed : '0;
    end
  end

  assign out_valid = v_s;

endmodule

@@ hw/rtl/hsc_gain.sv @@
// Gain, clamp and small-error boost stages; the last stage is the output register.
module hsc_gain
  import hsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_mag,
  input  cmd_side_t          in_side,
  input  logic [12:0]        turn_gain,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         robot_tag,
  output logic [10:0]        linear_speed,
  output logic signed [15:0] angular_speed
);

  logic        v1, v2, v3;
  logic        rdy1, rdy2, rdy3;
  logic [14:0] mag1;
  logic [15:0] mag2;
  cmd_side_t   side1, side2;

  logic [21:0] p1, p2, p3;
  logic [14:0] mag1_next;
  logic [15:0] mag2_next, mag3;

  always_comb begin
    p1        = gain_mul(in_mag, turn_gain);
    mag1_next = (p1 > {7'b0, PI_PLUS_ONE_Q12}) ? PI_PLUS_ONE_Q12 : p1[14:0];
  end

  always_comb begin
    p2        = gain_mul({1'b0, mag1}, turn_gain);
    mag2_next = (mag1 < BOOST1_LIMIT) ? p2[15:0] : {1'b0, mag1};
  end

  always_comb begin
    p3   = gain_mul(mag2, turn_gain);
    mag3 = (mag2 < BOOST2_LIMIT) ? p3[15:0] : mag2;
  end

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mag1  <= mag1_next;
      side1 <= in_side;
    end
    if (rdy2) begin
      mag2  <= mag2_next;
      side2 <= side1;
    end
    if (rdy3) begin
      robot_tag     <= side2.id;
      linear_speed  <= side2.speed;
      angular_speed <= side2.neg ? -$signed(mag3) : $signed(mag3);
    end
  end

  assign out_valid = v3;

endmodule

@@ hw/rtl/heading_steering_controller.sv @@
// Top level of the heading steering controller: ports, configuration registers, pipeline.
//
// Each input item carries a robot position, heading and target point; each one yields
// exactly one result item with a forward speed and a turn rate for that robot.
// Input items arrive on the s_axis channel and results leave on the m_axis channel,
// both with the usual tvalid/tready handshake. The robot index travels in tuser.
// The cfg channel writes turn_threshold (index 0), turn_gain (1) and cruise_speed (2);
// cfg_ready is always high and other indexes are ignored. Write it only while idle.
//
// The datapath is a pure pipeline of ITER + 7 register stages: one pre-rotation stage,
// one CORDIC stage per iteration, three stages for rounding and error selection, and
// three gain stages, the last of which is the output register. One item can enter
// every cycle while the result channel does not stall.
// Every stage holds a valid bit and only moves when its successor has room, so a
// stalled receiver backs the pipeline up without losing items, while empty stages
// still let new items in. Reset empties the pipeline and restores the register
// defaults; there is no memory to clear.
module heading_steering_controller
  import hsc_pkg::*;
#(
  parameter int ATAN_ITERATIONS = ATAN_ITERATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input item channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // robot_x[15:0], robot_y[31:16], robot_heading[46:32], target_x[62:47],
  // target_y[78:63], zero pad [79:79].
  input  logic [79:0] s_axis_tdata,
  // robot_id[1:0].
  input  logic [1:0]  s_axis_tuser,
  // Result item channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // linear_speed[10:0], angular_speed[26:11], zero pad [31:27].
  output logic [31:0] m_axis_tdata,
  // robot_tag[1:0].
  output logic [1:0]  m_axis_tuser,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  cfg_t cfg;

  // Configuration registers; the user must change them only while no item is in flight (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turn_threshold <= 14'd2048;
      cfg.turn_gain      <= 13'd2560;
      cfg.cruise_speed   <= 11'd1536;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TURN_THRESHOLD: cfg.turn_threshold <= cfg_data;
        REG_TURN_GAIN:      cfg.turn_gain      <= cfg_data[12:0];
        REG_CRUISE_SPEED:   cfg.cruise_speed   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Bearing stages.
  logic   cor_valid, cor_ready;
  angle_t cor_z;
  side_t  cor_side;

  hsc_cordic #(
    .ITER(ATAN_ITERATIONS)
  ) u_cordic (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .robot_id     (s_axis_tuser),
    .robot_x      (s_axis_tdata[15:0]),
    .robot_y      (s_axis_tdata[31:16]),
    .robot_heading($signed(s_axis_tdata[46:32])),
    .target_x     (s_axis_tdata[62:47]),
    .target_y     (s_axis_tdata[78:63]),
    .out_valid    (cor_valid),
    .out_ready    (cor_ready),
    .out_z        (cor_z),
    .out_side     (cor_side)
  );

  // Heading error and forward speed.
  logic        err_valid, err_ready;
  logic [15:0] err_mag;
  cmd_side_t   err_side;

  hsc_error u_error (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (cor_valid),
    .in_ready      (cor_ready),
    .in_z          (cor_z),
    .in_side       (cor_side),
    .turn_threshold(cfg.turn_threshold),
    .cruise_speed  (cfg.cruise_speed),
    .out_valid     (err_valid),
    .out_ready     (err_ready),
    .out_mag       (err_mag),
    .out_side      (err_side)
  );

  // Turn rate; its last stage drives the result channel directly.
  logic [10:0]        linear_speed;
  logic signed [15:0] angular_speed;

  hsc_gain u_gain (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (err_valid),
    .in_ready     (err_ready),
    .in_mag       (err_mag),
    .in_side      (err_side),
    .turn_gain    (cfg.turn_gain),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .robot_tag    (m_axis_tuser),
    .linear_speed (linear_speed),
    .angular_speed(angular_speed)
  );

  assign m_axis_tdata = {5'b0, angular_speed, linear_speed};

endmodule
